// ----- sv/pbrd_pkg.sv -----
// Shared types and constants for the pulse beat rate detector.
package pbrd_pkg;

   localparam int SAMPLE_W = 12;
   localparam int TIME_W   = 32;
   localparam int RATE_W   = 8;
   localparam int WEIGHT_W = 9;
   localparam int LEVEL_W  = 20;
   localparam int DIV_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [WEIGHT_W-1:0] WEIGHT_FULL   = 9'd256;
   localparam logic [TIME_W-1:0]   REFRACTORY_MS = 32'd300;
   localparam logic [DIV_W-1:0]    MS_PER_MINUTE = 16'd60000;
   localparam logic [DIV_W-1:0]    RATE_LOW      = 16'd40;
   localparam logic [DIV_W-1:0]    RATE_HIGH     = 16'd200;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_WEIGHT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEAT_THRESHOLD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS_WIDTH = 2'd2;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [TIME_W-1:0]   time_ms;
      logic                monitoring;
   } req_type;

   typedef struct packed {
      logic              pulse_high;
      logic              beat_seen;
      logic              rate_accepted;
      logic              average_sent;
      logic [RATE_W-1:0] beat_rate;
      logic [RATE_W-1:0] average_rate;
      logic              finger_present;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILT_A,
      ST_FILT_B,
      ST_LEVEL,
      ST_RATE,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_OUT
   } state_type;

endpackage

// ----- sv/pulse_beat_rate_detector.sv -----
// Pulse beat rate detector top level: filter, hysteresis, beat timing, rate averaging.
// Each sample runs the filter and level steps; a beat adds a rate division, and an accepted rate
// adds an averaging division; both divisions run on the shared divider.
// One sample at a time: req_ready is high only while the sequencer is idle.
// Reset (synchronous) restores register defaults and clears filter, beat time, rates and ring.
module pulse_beat_rate_detector #(
   parameter int RING_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pbrd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pbrd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pbrd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pbrd_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W = pbrd_pkg::RATE_W + CNT_W;
   localparam int ACC_W = pbrd_pkg::WEIGHT_W + pbrd_pkg::LEVEL_W;

   pbrd_pkg::state_type state_ff, state_in;

   logic [pbrd_pkg::WEIGHT_W-1:0]   weight_ff, weight_in;
   logic [pbrd_pkg::SAMPLE_W-1:0]   thr_ff, thr_in;
   logic [pbrd_pkg::SAMPLE_W-1:0]   hyst_ff, hyst_in;

   logic [pbrd_pkg::SAMPLE_W-1:0]   sample_ff, sample_in;
   logic [pbrd_pkg::TIME_W-1:0]     time_ff, time_in;
   logic                            mon_ff, mon_in;
   logic [ACC_W-1:0]                acc_ff, acc_in;
   logic [pbrd_pkg::LEVEL_W-1:0]    smoothed_ff, smoothed_in;
   logic                            prev_high_ff, prev_high_in;
   logic [pbrd_pkg::TIME_W-1:0]     last_beat_ff, last_beat_in;
   logic [pbrd_pkg::RATE_W-1:0]     rate_ff, rate_in;
   logic [pbrd_pkg::RATE_W-1:0]     avg_ff, avg_in;
   logic                            beat_ff, beat_in;
   logic                            accepted_ff, accepted_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   pbrd_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic [pbrd_pkg::WEIGHT_W-1:0]   w_sat;
   logic [pbrd_pkg::WEIGHT_W-1:0]   mul_a;
   logic [pbrd_pkg::LEVEL_W-1:0]    mul_b;
   logic [ACC_W-1:0]                prod;
   logic [ACC_W-1:0]                filt_sum;
   logic                            mul_sel_b;
   logic [pbrd_pkg::SAMPLE_W:0]     lower_diff;
   logic                            above;
   logic                            below;
   logic                            level_high;
   logic [pbrd_pkg::TIME_W-1:0]     delta;
   logic                            beat_go;
   logic                            rate_ok;
   logic                            out_free;

   logic                            div_start;
   logic [pbrd_pkg::DIV_W-1:0]      div_dividend;
   logic [pbrd_pkg::TIME_W-1:0]     div_divisor;
   logic                            div_busy;
   logic                            div_done;
   logic [pbrd_pkg::DIV_W-1:0]      div_quo;

   logic                            ring_wr;
   logic [SUM_W-1:0]                ring_sum;
   logic [CNT_W-1:0]                ring_count;

   pbrd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   pbrd_ring #(
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_wr),
      .wr_data (div_quo[pbrd_pkg::RATE_W-1:0]),
      .sum     (ring_sum),
      .count   (ring_count)
   );

   // shared filter multiplier
   assign w_sat    = (weight_ff > pbrd_pkg::WEIGHT_FULL) ? pbrd_pkg::WEIGHT_FULL : weight_ff;
   assign mul_a    = mul_sel_b ? (pbrd_pkg::WEIGHT_FULL - w_sat) : w_sat;
   assign mul_b    = mul_sel_b ? smoothed_ff : pbrd_pkg::LEVEL_W'(sample_ff);
   assign prod     = ACC_W'(mul_a) * ACC_W'(mul_b);
   assign filt_sum = acc_ff + prod;

   assign lower_diff = {1'b0, thr_ff} - {1'b0, hyst_ff};
   assign above      = smoothed_ff > {thr_ff, 8'b0};
   assign below      = !lower_diff[pbrd_pkg::SAMPLE_W]
                       && (smoothed_ff[pbrd_pkg::LEVEL_W-1:8] < lower_diff[pbrd_pkg::SAMPLE_W-1:0]);
   assign level_high = above ? 1'b1 : (below ? 1'b0 : prev_high_ff);
   assign delta      = time_ff - last_beat_ff;
   assign beat_go    = level_high && !prev_high_ff && (delta > pbrd_pkg::REFRACTORY_MS);
   assign rate_ok    = (div_quo > pbrd_pkg::RATE_LOW) && (div_quo < pbrd_pkg::RATE_HIGH);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbrd_pkg::ST_IDLE:      if (req_valid) state_in = pbrd_pkg::ST_FILT_A;
         pbrd_pkg::ST_FILT_A:    state_in = pbrd_pkg::ST_FILT_B;
         pbrd_pkg::ST_FILT_B:    state_in = pbrd_pkg::ST_LEVEL;
         pbrd_pkg::ST_LEVEL:     state_in = beat_go ? pbrd_pkg::ST_RATE : pbrd_pkg::ST_OUT;
         pbrd_pkg::ST_RATE: begin
            if (div_done) begin
               state_in = rate_ok ? pbrd_pkg::ST_AVG_START : pbrd_pkg::ST_OUT;
            end
         end
         pbrd_pkg::ST_AVG_START: state_in = pbrd_pkg::ST_AVG_WAIT;
         pbrd_pkg::ST_AVG_WAIT:  if (div_done) state_in = pbrd_pkg::ST_OUT;
         pbrd_pkg::ST_OUT:       if (out_free) state_in = pbrd_pkg::ST_IDLE;
         default:                state_in = pbrd_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready    = 1'b0;
      mul_sel_b    = 1'b0;
      div_start    = 1'b0;
      div_dividend = pbrd_pkg::MS_PER_MINUTE;
      div_divisor  = delta;
      ring_wr      = 1'b0;
      case (state_ff)
         pbrd_pkg::ST_IDLE:      req_ready = 1'b1;
         pbrd_pkg::ST_FILT_B:    mul_sel_b = 1'b1;
         pbrd_pkg::ST_LEVEL:     div_start = beat_go;
         pbrd_pkg::ST_RATE:      ring_wr   = div_done && rate_ok;
         pbrd_pkg::ST_AVG_START: begin
            div_start    = 1'b1;
            div_dividend = pbrd_pkg::DIV_W'(ring_sum);
            div_divisor  = pbrd_pkg::TIME_W'(ring_count);
         end
         default:                req_ready = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      weight_in    = weight_ff;
      thr_in       = thr_ff;
      hyst_in      = hyst_ff;
      sample_in    = sample_ff;
      time_in      = time_ff;
      mon_in       = mon_ff;
      acc_in       = acc_ff;
      smoothed_in  = smoothed_ff;
      prev_high_in = prev_high_ff;
      last_beat_in = last_beat_ff;
      rate_in      = rate_ff;
      avg_in       = avg_ff;
      beat_in      = beat_ff;
      accepted_in  = accepted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         case (csr_index)
            pbrd_pkg::CSR_FILTER_WEIGHT:    weight_in = csr_data[pbrd_pkg::WEIGHT_W-1:0];
            pbrd_pkg::CSR_BEAT_THRESHOLD:   thr_in    = csr_data;
            pbrd_pkg::CSR_HYSTERESIS_WIDTH: hyst_in   = csr_data;
            default:                        weight_in = weight_ff;
         endcase
      end

      case (state_ff)
         pbrd_pkg::ST_IDLE: begin
            if (req_valid) begin
               sample_in   = req_data.sample;
               time_in     = req_data.time_ms;
               mon_in      = req_data.monitoring;
               beat_in     = 1'b0;
               accepted_in = 1'b0;
            end
         end
         pbrd_pkg::ST_FILT_A: acc_in = {prod[ACC_W-9:0], 8'b0};
         pbrd_pkg::ST_FILT_B: smoothed_in = filt_sum[pbrd_pkg::LEVEL_W+7:8];
         pbrd_pkg::ST_LEVEL: begin
            prev_high_in = level_high;
            if (beat_go) begin
               beat_in      = 1'b1;
               last_beat_in = time_ff;
            end
         end
         pbrd_pkg::ST_RATE: begin
            if (div_done) begin
               rate_in     = div_quo[pbrd_pkg::RATE_W-1:0];
               accepted_in = rate_ok;
            end
         end
         pbrd_pkg::ST_AVG_WAIT: begin
            if (div_done) avg_in = div_quo[pbrd_pkg::RATE_W-1:0];
         end
         pbrd_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.pulse_high     = prev_high_ff;
               rsp_data_in.beat_seen      = beat_ff;
               rsp_data_in.rate_accepted  = accepted_ff;
               rsp_data_in.average_sent   = accepted_ff && mon_ff;
               rsp_data_in.beat_rate      = rate_ff;
               rsp_data_in.average_rate   = avg_ff;
               rsp_data_in.finger_present = rate_ff != '0;
            end
         end
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbrd_pkg::ST_IDLE;
         weight_ff    <= 9'd26;
         thr_ff       <= 12'd2048;
         hyst_ff      <= 12'd100;
         smoothed_ff  <= '0;
         prev_high_ff <= 1'b0;
         last_beat_ff <= '0;
         rate_ff      <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         weight_ff    <= weight_in;
         thr_ff       <= thr_in;
         hyst_ff      <= hyst_in;
         smoothed_ff  <= smoothed_in;
         prev_high_ff <= prev_high_in;
         last_beat_ff <= last_beat_in;
         rate_ff      <= rate_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_in_reg: begin
         sample_ff   <= sample_in;
         time_ff     <= time_in;
         mon_ff      <= mon_in;
         acc_ff      <= acc_in;
         beat_ff     <= beat_in;
         accepted_ff <= accepted_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_idle_div_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pbrd_pkg::ST_IDLE) |-> !div_busy)
      else $error("divider busy while sequencer idle");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == pbrd_pkg::ST_RATE || state_ff == pbrd_pkg::ST_AVG_WAIT))
      else $error("divider result outside a wait state");

   a_accept_needs_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.rate_accepted) |-> rsp_data_ff.beat_seen)
      else $error("rate accepted without a beat");

   a_ring_write_on_beat: assert property (@(posedge clock) disable iff (reset)
      ring_wr |-> (beat_ff && $past(div_start, 17)))
      else $error("ring write without a rate division");

endmodule

// ----- sv/pbrd_divider.sv -----
// Shared restoring divider, one quotient bit per cycle.
module pbrd_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pbrd_pkg::DIV_W-1:0]  dividend,
   input  logic [pbrd_pkg::TIME_W-1:0] divisor,
   output logic                        busy,
   output logic                        done,
   output logic [pbrd_pkg::DIV_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(pbrd_pkg::DIV_W + 1);
   localparam int REM_W = pbrd_pkg::TIME_W;

   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [REM_W-1:0]          dvs_ff, dvs_in;
   logic [pbrd_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [REM_W:0]            shifted;
   logic [REM_W:0]            trial;
   logic                      ge;

   assign shifted = {rem_ff, quo_ff[pbrd_pkg::DIV_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign ge      = !trial[REM_W];

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         cnt_in  = CNT_W'(pbrd_pkg::DIV_W);
         busy_in = 1'b1;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? trial[REM_W-1:0] : shifted[REM_W-1:0];
         quo_in = {quo_ff[pbrd_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- sv/pbrd_ring.sv -----
// Ring of recent rates with running sum and nonzero count.
module pbrd_ring #(
   parameter int DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [pbrd_pkg::RATE_W-1:0]         wr_data,
   output logic [pbrd_pkg::RATE_W+$clog2(DEPTH+1)-1:0] sum,
   output logic [$clog2(DEPTH+1)-1:0]          count
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = pbrd_pkg::RATE_W + CNT_W;

   logic [pbrd_pkg::RATE_W-1:0] entry_ff [DEPTH];
   logic [IDX_W-1:0]            pos_ff, pos_in;
   logic [SUM_W-1:0]            sum_ff, sum_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [pbrd_pkg::RATE_W-1:0] old_entry;

   assign old_entry = entry_ff[pos_ff];

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (wr_en) begin
         pos_in   = (pos_ff == IDX_W'(DEPTH - 1)) ? '0 : pos_ff + 1'b1;
         sum_in   = sum_ff - SUM_W'(old_entry) + SUM_W'(wr_data);
         count_in = count_ff + CNT_W'(wr_data != '0) - CNT_W'(old_entry != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
         for (int i = 0; i < DEPTH; i++) begin
            entry_ff[i] <= '0;
         end
      end else begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         if (wr_en) begin
            entry_ff[pos_ff] <= wr_data;
         end
      end
   end

   assign sum   = sum_ff;
   assign count = count_ff;

endmodule
